FILE: src/wtrl_pkg.sv
// Package: shared constants for the windowed task rate limiter.
`default_nettype none

package wtrl_pkg;

    // Default structural widths
    localparam int TIME_WIDTH_DEF  = 48;
    localparam int COUNT_WIDTH_DEF = 17;

    // Fixed field and register widths
    localparam int THR_W     = 16;
    localparam int PERIOD_W  = 40;
    localparam int RAND_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 8;

    // Item kinds carried on tuser
    localparam logic FUNC_TASK  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITED_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_SPAN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_WINDOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELIVERY_WINDOW   = 3'd4;

    // Register reset values
    localparam logic [THR_W-1:0]    NORMAL_THRESHOLD_RST  = 16'd100;
    localparam logic [THR_W-1:0]    LIMITED_THRESHOLD_RST = 16'd10;
    localparam logic [PERIOD_W-1:0] LOCKOUT_SPAN_RST      = 40'd20000000000;
    localparam logic [PERIOD_W-1:0] TASK_WINDOW_RST       = 40'd1000000000;
    localparam logic [PERIOD_W-1:0] DELIVERY_WINDOW_RST   = 40'd1000000000;

endpackage

`default_nettype wire

FILE: src/windowed_task_rate_limiter.sv
// Windowed task rate limiter: fixed-window task and delivery counting with lock-out.
// Path: an item goes through the input register and then the result register to m_*; the lock-out
//   duration multiply (period/2 x rand_word) is done as the item is taken.
// Throughput: one item per cycle while m_tready is high; all state is read and rewritten in
//   the single compute stage, so back-to-back items always see the state left by the one before.
// Reset (rst_n low, asynchronous): state clears, registers to defaults, both stages empty.
`default_nettype none

module windowed_task_rate_limiter #(
    parameter int TIME_WIDTH  = wtrl_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = wtrl_pkg::COUNT_WIDTH_DEF,
    // derived; not meant to be overridden
    parameter int IN_DATA_W   = ((TIME_WIDTH + wtrl_pkg::RAND_W + 7) / 8) * 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // Configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [wtrl_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [wtrl_pkg::PERIOD_W-1:0]  cfg_wdata,

    // Input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [IN_DATA_W-1:0]           s_tdata,   // now, rand_word, zero pad
    input  wire logic                           s_tuser,   // func: 0 task event, 1 query

    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [wtrl_pkg::OUT_W-1:0]          m_tdata    // deliver_ok, limited, zero pad
);

    localparam int PERIOD_W = wtrl_pkg::PERIOD_W;
    localparam int THR_W    = wtrl_pkg::THR_W;
    localparam int RAND_W   = wtrl_pkg::RAND_W;
    localparam int HALF_W   = PERIOD_W - 1;
    localparam int PROD_W   = HALF_W + RAND_W;
    localparam int SUM_W    = ((TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W) + 1;
    localparam int CMP_W    = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Saturating time add: any sum at or above the top code pins there
    function automatic logic [TIME_WIDTH-1:0] time_add_sat(
        input logic [TIME_WIDTH-1:0] a,
        input logic [PERIOD_W-1:0]   b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(TIME_MAX))
            return TIME_MAX;
        return s[TIME_WIDTH-1:0];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] count_inc_sat(input logic [COUNT_WIDTH-1:0] c);
        if (c == COUNT_MAX)
            return COUNT_MAX;
        return c + COUNT_WIDTH'(1);
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [THR_W-1:0]    normal_thr_reg;
    logic [THR_W-1:0]    limited_thr_reg;
    logic [PERIOD_W-1:0] lockout_span_reg;
    logic [PERIOD_W-1:0] task_window_reg;
    logic [PERIOD_W-1:0] delivery_window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_thr_reg      <= wtrl_pkg::NORMAL_THRESHOLD_RST;
            limited_thr_reg     <= wtrl_pkg::LIMITED_THRESHOLD_RST;
            lockout_span_reg    <= wtrl_pkg::LOCKOUT_SPAN_RST;
            task_window_reg     <= wtrl_pkg::TASK_WINDOW_RST;
            delivery_window_reg <= wtrl_pkg::DELIVERY_WINDOW_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                wtrl_pkg::REG_NORMAL_THRESHOLD:  normal_thr_reg      <= cfg_wdata[THR_W-1:0];
                wtrl_pkg::REG_LIMITED_THRESHOLD: limited_thr_reg     <= cfg_wdata[THR_W-1:0];
                wtrl_pkg::REG_LOCKOUT_SPAN:      lockout_span_reg    <= cfg_wdata;
                wtrl_pkg::REG_TASK_WINDOW:       task_window_reg     <= cfg_wdata;
                wtrl_pkg::REG_DELIVERY_WINDOW:   delivery_window_reg <= cfg_wdata;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: input register feeds the compute stage, result register
    // decouples the output; the input side keeps taking transfers while
    // a finished result waits, as long as the result register can move.
    // ---------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Input register; lock-out duration is formed here so the compute
    // stage only sees one saturating add on it.
    // dur = half + (half * rand_word) >> 16, half = lock-out span / 2
    // ---------------------------------------------------------------
    logic [HALF_W-1:0]   half;
    logic [PROD_W-1:0]   scaled;
    logic [PERIOD_W-1:0] dur_next;

    assign half     = lockout_span_reg[PERIOD_W-1:1];
    assign scaled   = PROD_W'(half) * PROD_W'(s_tdata[TIME_WIDTH+RAND_W-1:TIME_WIDTH]);
    assign dur_next = PERIOD_W'(half) + PERIOD_W'(scaled[PROD_W-1:RAND_W]);

    logic                  func_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [PERIOD_W-1:0]   dur_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser;
            now_reg  <= s_tdata[TIME_WIDTH-1:0];
            dur_reg  <= dur_next;
        end
    end

    // ---------------------------------------------------------------
    // Limiter state and compute stage
    // ---------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] task_count_reg,          task_count_next;
    logic [TIME_WIDTH-1:0]  task_window_end_reg,     task_window_end_next;
    logic [COUNT_WIDTH-1:0] delivery_count_reg,      delivery_count_next;
    logic [TIME_WIDTH-1:0]  delivery_window_end_reg, delivery_window_end_next;
    logic [TIME_WIDTH-1:0]  limit_end_reg,           limit_end_next;
    logic                   deliver_ok_reg,          deliver_ok_next;
    logic                   limited_reg,             limited_next;

    logic                   task_restart;
    logic [COUNT_WIDTH-1:0] task_base;
    logic [COUNT_WIDTH-1:0] task_inc;
    logic                   task_trip;
    logic                   dlv_restart;
    logic [COUNT_WIDTH-1:0] dlv_base;
    logic [THR_W-1:0]       active_thr;
    logic                   grant;

    always_comb
    begin
        task_count_next          = task_count_reg;
        task_window_end_next     = task_window_end_reg;
        delivery_count_next      = delivery_count_reg;
        delivery_window_end_next = delivery_window_end_reg;
        limit_end_next           = limit_end_reg;
        deliver_ok_next          = 1'b0;

        // task path
        task_restart = now_reg > task_window_end_reg;
        task_base    = task_restart ? '0 : task_count_reg;
        task_inc     = count_inc_sat(task_base);
        task_trip    = CMP_W'(task_inc) > CMP_W'(normal_thr_reg);

        // delivery path; limit end is untouched by queries, so the old value decides
        dlv_restart  = now_reg > delivery_window_end_reg;
        dlv_base     = dlv_restart ? '0 : delivery_count_reg;
        active_thr   = (now_reg < limit_end_reg) ? limited_thr_reg : normal_thr_reg;
        grant        = CMP_W'(dlv_base) < CMP_W'(active_thr);

        if (func_reg == wtrl_pkg::FUNC_TASK)
        begin
            // task events while locked out are dropped
            if (now_reg > limit_end_reg)
            begin
                if (task_restart)
                    task_window_end_next = time_add_sat(now_reg, task_window_reg);
                task_count_next = task_inc;
                if (task_trip)
                    limit_end_next = time_add_sat(now_reg, dur_reg);
            end
        end
        else
        begin
            if (dlv_restart)
                delivery_window_end_next = time_add_sat(now_reg, delivery_window_reg);
            delivery_count_next = grant ? count_inc_sat(dlv_base) : dlv_base;
            deliver_ok_next     = grant;
        end

        limited_next = now_reg < limit_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg          <= '0;
            task_window_end_reg     <= '0;
            delivery_count_reg      <= '0;
            delivery_window_end_reg <= '0;
            limit_end_reg           <= '0;
        end
        else if (advance)
        begin
            task_count_reg          <= task_count_next;
            task_window_end_reg     <= task_window_end_next;
            delivery_count_reg      <= delivery_count_next;
            delivery_window_end_reg <= delivery_window_end_next;
            limit_end_reg           <= limit_end_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            deliver_ok_reg <= deliver_ok_next;
            limited_reg    <= limited_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(wtrl_pkg::OUT_W - 2)'(0), limited_reg, deliver_ok_reg};

`ifndef SYNTH
    // a task event never yields a grant
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (func_reg == wtrl_pkg::FUNC_TASK)) |=> !deliver_ok_reg)
        else $error("grant reported for a task event");

    // the limit end only moves when a task event is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(limit_end_reg) |-> $past(advance && (func_reg == wtrl_pkg::FUNC_TASK)))
        else $error("limit end moved without a task event");

    // window ends only ever move forward
    assert property (@(posedge clk) disable iff (!rst_n)
        (task_window_end_reg >= $past(task_window_end_reg)) &&
        (delivery_window_end_reg >= $past(delivery_window_end_reg)))
        else $error("window end moved backwards");

    // deliveries are bounded by the 16-bit thresholds
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(delivery_count_reg) <= CMP_W'({THR_W{1'b1}}))
        else $error("delivery count beyond any threshold");

    // an empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
